// ===== sv/kms_pkg.sv =====
// Shared types, operation codes and controller/datapath interface for the keyframe sequencer.
`default_nettype none

package kms_pkg;

    localparam int KMS_JOINTS = 18;
    localparam int KMS_FRAMES = 64;

    localparam logic [2:0] OP_SELECT = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_LINK   = 3'd3;
    localparam logic [2:0] OP_WAIT   = 3'd4;
    localparam logic [2:0] OP_START  = 3'd5;
    localparam logic [2:0] OP_STOP   = 3'd6;
    localparam logic [2:0] OP_TICK   = 3'd7;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [15:0] frame_number;
        logic [7:0]         joint;
        logic [15:0]        position;
        logic [15:0]        speed;
        logic [15:0]        wait_ms;
        logic [31:0]        now_ms;
    } req_t;

    typedef struct packed {
        logic [7:0]  cmd_joint;
        logic [15:0] cmd_position;
        logic [15:0] cmd_speed;
        logic        last_command;
    } cmd_t;

    typedef struct packed {
        logic sweep;
        logic capture;
        logic select;
        logic mask_clear;
        logic mask_rd_edit;
        logic mask_set;
        logic ps_write;
        logic link_write;
        logic wait_write;
        logic start;
        logic stop;
        logic frame_rd;
        logic advance;
        logic mask_rd_play;
        logic mask_load;
        logic scan_step;
        logic emit;
    } ctl_t;

    typedef struct packed {
        logic       sweep_done;
        logic [2:0] op;
        logic       fnum_ok;
        logic       joint_ok;
        logic       play_valid;
        logic       advance_ok;
        logic       mask_empty;
        logic       pend_last;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== sv/kms_datapath.sv =====
// Frame tables, playback registers, joint scan and command output register.
`default_nettype none

module kms_datapath #(
    parameter int JOINTS = kms_pkg::KMS_JOINTS,
    parameter int FRAMES = kms_pkg::KMS_FRAMES
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire kms_pkg::req_t req_data,
    input  wire kms_pkg::ctl_t ctl,
    output kms_pkg::sts_t      sts,
    input  wire logic          cmd_stall,
    output logic               cmd_valid,
    output kms_pkg::cmd_t      cmd_data
);
    import kms_pkg::*;

    localparam int FW    = $clog2(FRAMES);
    localparam int CW    = FW + 1;
    localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int DEPTH = FRAMES * JOINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // frame tables: set mask per frame, {valid, index} link, wait
    logic [JOINTS-1:0] mask_mem [FRAMES];
    logic [FW:0]       link_mem [FRAMES];
    logic [15:0]       wait_mem [FRAMES];
    // joint table: {position, speed}, read only for joints marked set
    logic [31:0]       ps_mem   [DEPTH];

    req_t              req_reg;
    logic [JOINTS-1:0] mask_rdata_reg;
    logic [FW:0]       link_rdata_reg;
    logic [15:0]       wait_rdata_reg;
    logic [31:0]       ps_rdata_reg;
    logic [JW-1:0]     pend_joint_reg;
    logic              pend_last_reg;
    cmd_t              cmd_reg;

    logic [CW-1:0]     sweep_reg,      sweep_next;
    logic [FW-1:0]     edit_frame_reg, edit_frame_next;
    logic [AW-1:0]     edit_base_reg,  edit_base_next;
    logic              play_valid_reg, play_valid_next;
    logic [FW-1:0]     play_frame_reg, play_frame_next;
    logic [AW-1:0]     play_base_reg,  play_base_next;
    logic [31:0]       start_time_reg, start_time_next;
    logic [JOINTS-1:0] mask_reg,       mask_next;
    logic              cmd_valid_reg,  cmd_valid_next;

    logic              fnum_ok;
    logic              joint_ok;
    logic [FW-1:0]     fnum_idx;
    logic [JW-1:0]     joint_idx;
    logic [FW-1:0]     link_idx;
    logic [31:0]       elapsed;
    logic              advance_ok;
    logic [JW-1:0]     low_idx;
    logic [JOINTS-1:0] mask_after;
    logic [JOINTS-1:0] mask_set;
    logic              mask_we;
    logic [FW-1:0]     mask_waddr;
    logic [JOINTS-1:0] mask_wdata;
    logic              link_we;
    logic [FW-1:0]     link_waddr;
    logic [FW:0]       link_wdata;
    logic              wait_we;
    logic [FW-1:0]     wait_waddr;
    logic [15:0]       wait_wdata;
    logic              out_free;

    assign fnum_ok   = !req_reg.frame_number[15] && (int'(req_reg.frame_number) < FRAMES);
    assign joint_ok  = int'(req_reg.joint) < JOINTS;
    assign fnum_idx  = req_reg.frame_number[FW-1:0];
    assign joint_idx = req_reg.joint[JW-1:0];
    assign link_idx  = link_rdata_reg[FW-1:0];

    // time difference wraps modulo 2^32
    assign elapsed    = req_reg.now_ms - start_time_reg;
    assign advance_ok = link_rdata_reg[FW] && (elapsed >= {16'b0, wait_rdata_reg});

    // lowest set joint still pending in this frame
    always_comb
    begin
        low_idx = '0;
        for (int i = JOINTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_idx = JW'(i);
            end
        end
    end

    assign mask_after = mask_reg & (mask_reg - 1'b1);

    always_comb
    begin
        mask_set            = mask_rdata_reg;
        mask_set[joint_idx] = 1'b1;
    end

    always_comb
    begin
        mask_we    = 1'b0;
        mask_waddr = edit_frame_reg;
        mask_wdata = '0;
        if (ctl.sweep)
        begin
            mask_we    = 1'b1;
            mask_waddr = sweep_reg[FW-1:0];
        end
        else if (ctl.mask_clear)
        begin
            mask_we = 1'b1;
        end
        else if (ctl.mask_set)
        begin
            mask_we    = 1'b1;
            mask_wdata = mask_set;
        end
    end

    always_comb
    begin
        link_we    = ctl.sweep || ctl.link_write;
        link_waddr = ctl.sweep ? sweep_reg[FW-1:0] : edit_frame_reg;
        // reset value is frame zero, anything out of range ends the sequence
        link_wdata = ctl.sweep ? {1'b1, {FW{1'b0}}} : {fnum_ok, fnum_idx};
        wait_we    = ctl.sweep || ctl.wait_write;
        wait_waddr = link_waddr;
        wait_wdata = ctl.sweep ? 16'd0 : req_reg.wait_ms;
    end

    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        if (ctl.mask_rd_edit || ctl.mask_rd_play)
        begin
            mask_rdata_reg <= mask_mem[ctl.mask_rd_edit ? edit_frame_reg : play_frame_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (wait_we)
        begin
            wait_mem[wait_waddr] <= wait_wdata;
        end
        if (ctl.frame_rd)
        begin
            link_rdata_reg <= link_mem[play_frame_reg];
            wait_rdata_reg <= wait_mem[play_frame_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ps_write)
        begin
            ps_mem[edit_base_reg + AW'(joint_idx)] <= {req_reg.position, req_reg.speed};
        end
        if (ctl.scan_step)
        begin
            ps_rdata_reg <= ps_mem[play_base_reg + AW'(low_idx)];
        end
    end

    assign out_free = !cmd_valid_reg || !cmd_stall;

    always_comb
    begin
        sweep_next      = sweep_reg;
        edit_frame_next = edit_frame_reg;
        edit_base_next  = edit_base_reg;
        play_valid_next = play_valid_reg;
        play_frame_next = play_frame_reg;
        play_base_next  = play_base_reg;
        start_time_next = start_time_reg;
        mask_next       = mask_reg;
        cmd_valid_next  = cmd_valid_reg && cmd_stall;

        if (ctl.sweep)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
        if (ctl.select)
        begin
            edit_frame_next = fnum_idx;
            edit_base_next  = AW'(fnum_idx * JOINTS);
        end
        if (ctl.start)
        begin
            play_valid_next = 1'b1;
            play_frame_next = fnum_idx;
            play_base_next  = AW'(fnum_idx * JOINTS);
            start_time_next = req_reg.now_ms;
        end
        else if (ctl.advance)
        begin
            play_valid_next = 1'b1;
            play_frame_next = link_idx;
            play_base_next  = AW'(link_idx * JOINTS);
            start_time_next = req_reg.now_ms;
        end
        else if (ctl.stop)
        begin
            play_valid_next = 1'b0;
        end
        if (ctl.mask_load)
        begin
            mask_next = mask_rdata_reg;
        end
        else if (ctl.scan_step)
        begin
            mask_next = mask_after;
        end
        if (ctl.emit)
        begin
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg      <= '0;
            edit_frame_reg <= '0;
            edit_base_reg  <= '0;
            play_valid_reg <= 1'b0;
            play_frame_reg <= '0;
            play_base_reg  <= '0;
            start_time_reg <= '0;
            mask_reg       <= '0;
            cmd_valid_reg  <= 1'b0;
        end
        else
        begin
            sweep_reg      <= sweep_next;
            edit_frame_reg <= edit_frame_next;
            edit_base_reg  <= edit_base_next;
            play_valid_reg <= play_valid_next;
            play_frame_reg <= play_frame_next;
            play_base_reg  <= play_base_next;
            start_time_reg <= start_time_next;
            mask_reg       <= mask_next;
            cmd_valid_reg  <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= req_data;
        end
        if (ctl.scan_step)
        begin
            pend_joint_reg <= low_idx;
            pend_last_reg  <= (mask_after == '0);
        end
        if (ctl.emit)
        begin
            cmd_reg.cmd_joint    <= 8'(pend_joint_reg);
            cmd_reg.cmd_position <= ps_rdata_reg[31:16];
            cmd_reg.cmd_speed    <= ps_rdata_reg[15:0];
            cmd_reg.last_command <= pend_last_reg;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_data  = cmd_reg;

    assign sts.sweep_done = (sweep_reg == CW'(FRAMES));
    assign sts.op         = req_reg.operation;
    assign sts.fnum_ok    = fnum_ok;
    assign sts.joint_ok   = joint_ok;
    assign sts.play_valid = play_valid_reg;
    assign sts.advance_ok = advance_ok;
    assign sts.mask_empty = (mask_reg == '0);
    assign sts.pend_last  = pend_last_reg;
    assign sts.out_free   = out_free;

endmodule

`default_nettype wire

// ===== sv/kms_ctrl.sv =====
// Controller state machine: sequences table sweeps, edits, playback and command emission.
`default_nettype none

module kms_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire kms_pkg::sts_t sts,
    output kms_pkg::ctl_t      ctl
);
    import kms_pkg::*;

    localparam logic [3:0] ST_SWEEP   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_EXEC    = 4'd2;
    localparam logic [3:0] ST_JWRITE  = 4'd3;
    localparam logic [3:0] ST_TICK    = 4'd4;
    localparam logic [3:0] ST_MASK_RD = 4'd5;
    localparam logic [3:0] ST_MASK_LD = 4'd6;
    localparam logic [3:0] ST_SCAN    = 4'd7;
    localparam logic [3:0] ST_EMIT    = 4'd8;

    logic [3:0] state_reg, state_next;

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sts.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.sweep = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (sts.op)
                    OP_SELECT: ctl.select     = sts.fnum_ok;
                    OP_CLEAR:  ctl.mask_clear = 1'b1;
                    OP_WRITE:
                    begin
                        if (sts.joint_ok)
                        begin
                            ctl.ps_write     = 1'b1;
                            ctl.mask_rd_edit = 1'b1;
                            state_next       = ST_JWRITE;
                        end
                    end
                    OP_LINK:   ctl.link_write = 1'b1;
                    OP_WAIT:   ctl.wait_write = 1'b1;
                    OP_START:
                    begin
                        if (sts.fnum_ok)
                        begin
                            ctl.start  = 1'b1;
                            state_next = ST_MASK_RD;
                        end
                    end
                    OP_STOP:   ctl.stop = 1'b1;
                    OP_TICK:
                    begin
                        if (sts.play_valid)
                        begin
                            ctl.frame_rd = 1'b1;
                            state_next   = ST_TICK;
                        end
                    end
                    default: ;
                endcase
            end
            ST_JWRITE:
            begin
                // merge the new joint into the frame's set mask
                ctl.mask_set = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_TICK:
            begin
                if (sts.advance_ok)
                begin
                    ctl.advance = 1'b1;
                    state_next  = ST_MASK_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MASK_RD:
            begin
                ctl.mask_rd_play = 1'b1;
                state_next       = ST_MASK_LD;
            end
            ST_MASK_LD:
            begin
                ctl.mask_load = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.mask_empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold until the output register frees up
                if (sts.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = sts.pend_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/keyframe_motor_sequencer.sv =====
// Keyframe motor sequencer top level: controller and datapath.
// After reset the block sweeps the frame tables (set marks and waits cleared, links set to
// frame zero) and holds req_stall high meanwhile. One request is handled at a time. Edit
// requests (select, clear, write joint, link, wait) and stop are done in the execute state,
// a joint write also merging its joint into the frame's set mask. A start, or a tick that moves
// to the next frame, reads the new frame's set mask, loads it and then sends one command per
// set joint. A tick that does not advance returns to idle, as does any tick while nothing plays.
// Each command takes one read of the single-port joint table and then a load of the output
// register; a stalled command output holds the scan.
// Commands go out in rising joint order with last_command set on the final one.
`default_nettype none

module keyframe_motor_sequencer #(
    parameter int JOINTS = kms_pkg::KMS_JOINTS,
    parameter int FRAMES = kms_pkg::KMS_FRAMES
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire kms_pkg::req_t req_data,
    output logic               cmd_valid,
    input  wire logic          cmd_stall,
    output kms_pkg::cmd_t      cmd_data
);
    import kms_pkg::*;

    ctl_t ctl;
    sts_t sts;

    kms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    kms_datapath #(
        .JOINTS (JOINTS),
        .FRAMES (FRAMES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .ctl       (ctl),
        .sts       (sts),
        .cmd_stall (cmd_stall),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/keyframe_motor_sequencer_test.sv =====
// Self-checking testbench for the keyframe motor sequencer: directed and random requests.
`timescale 1ns / 100ps

module keyframe_motor_sequencer_test;

    import kms_pkg::*;

    localparam int JOINTS          = KMS_JOINTS;
    localparam int FRAMES          = KMS_FRAMES;
    localparam int END_LINK        = -1;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 60;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req_data  = '0;
    logic cmd_stall = 1'b0;
    logic req_stall;
    logic cmd_valid;
    cmd_t cmd_data;

    // Frame table as the block should hold it
    logic [15:0] tbl_pos [FRAMES*JOINTS];
    logic [15:0] tbl_spd [FRAMES*JOINTS];
    bit          tbl_set [FRAMES*JOINTS];
    int          link_to [FRAMES];
    logic [15:0] hold_ms [FRAMES];
    int          edit_idx;
    int          play_idx;
    logic [31:0] play_t0;

    cmd_t        cmd_expect[$];
    logic [31:0] wall_ms;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          requests_sent  = 0;
    int          cmds_checked   = 0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;

    keyframe_motor_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data)
    );

    always #5 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Queue one command per set joint of frame f, last_command on the final one
    function automatic void expect_frame_cmds(input int f);
        bit   have;
        cmd_t c;
        have = 1'b0;
        c    = '0;
        for (int j = 0; j < JOINTS; j++) begin
            if (tbl_set[f*JOINTS + j]) begin
                if (have)
                    cmd_expect.push_back(c);
                c.cmd_joint    = 8'(j);
                c.cmd_position = tbl_pos[f*JOINTS + j];
                c.cmd_speed    = tbl_spd[f*JOINTS + j];
                c.last_command = 1'b0;
                have           = 1'b1;
            end
        end
        if (have)
        begin
            c.last_command = 1'b1;
            cmd_expect.push_back(c);
        end
    endfunction

    function automatic void predict_request(input req_t r);
        int          fn;
        int          base;
        int          nxt;
        logic [31:0] elapsed;
        fn   = $signed(r.frame_number);
        base = edit_idx * JOINTS;
        case (r.operation)
            OP_SELECT:
                if (fn >= 0 && fn < FRAMES)
                    edit_idx = fn;
            OP_CLEAR:
                for (int j = 0; j < JOINTS; j++) begin
                    tbl_pos[base + j] = '0;
                    tbl_spd[base + j] = '0;
                    tbl_set[base + j] = 1'b0;
                end
            OP_WRITE:
                if (r.joint < JOINTS)
                begin
                    tbl_pos[base + r.joint] = r.position;
                    tbl_spd[base + r.joint] = r.speed;
                    tbl_set[base + r.joint] = 1'b1;
                end
            OP_LINK:
                link_to[edit_idx] = (fn < END_LINK || fn >= FRAMES) ? END_LINK : fn;
            OP_WAIT:
                hold_ms[edit_idx] = r.wait_ms;
            OP_START:
                if (fn >= 0 && fn < FRAMES)
                begin
                    play_idx = fn;
                    expect_frame_cmds(fn);
                    play_t0 = r.now_ms;
                end
            OP_STOP:
                play_idx = END_LINK;
            default:
                if (play_idx >= 0)
                begin
                    nxt = link_to[play_idx];
                    if (nxt >= 0)
                    begin
                        // elapsed time wraps modulo 2^32
                        elapsed = r.now_ms - play_t0;
                        if (elapsed >= {16'd0, hold_ms[play_idx]})
                        begin
                            play_idx = nxt;
                            expect_frame_cmds(nxt);
                            play_t0 = r.now_ms;
                        end
                    end
                end
        endcase
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 5);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        predict_request(r);
        requests_sent++;
    endtask

    task automatic issue(input logic [2:0] op, input int fn, input int jt, input int pos,
                         input int spd, input int hold, input logic [31:0] now);
        req_t r;
        r.operation    = op;
        r.frame_number = 16'(fn);
        r.joint        = 8'(jt);
        r.position     = 16'(pos);
        r.speed        = 16'(spd);
        r.wait_ms      = 16'(hold);
        r.now_ms       = now;
        send_request(r);
    endtask

    // Mostly a handful of frames so links chain up; now and then any frame
    function automatic int pick_frame();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, FRAMES - 1);
        return $urandom_range(0, 7);
    endfunction

    task automatic test_joint_writes();
        issue(OP_SELECT, 1, 0, 0, 0, 0, 0);
        issue(OP_WRITE, 0, 0, 16'hFFFF, 16'h0000, 0, 0);
        issue(OP_WRITE, 0, JOINTS - 1, 16'h0000, 16'hFFFF, 0, 0);
        issue(OP_WRITE, 0, JOINTS, 16'h1111, 16'h2222, 0, 0);
        issue(OP_WAIT, 0, 0, 0, 0, 16'hFFFF, 0);
        issue(OP_LINK, 2, 0, 0, 0, 0, 0);
        issue(OP_SELECT, 2, 0, 0, 0, 0, 0);
        issue(OP_WRITE, 0, 5, 16'h1234, 16'h5678, 0, 0);
        issue(OP_LINK, -2, 0, 0, 0, 0, 0);
        issue(OP_SELECT, FRAMES, 0, 0, 0, 0, 0);
    endtask

    task automatic test_playback_wrap();
        issue(OP_START, 1, 0, 0, 0, 0, 32'hFFFF_FFF0);
        // one ms short of the wait across the wrap: hold
        issue(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_FFEE);
        issue(OP_WRITE, 0, 9, 16'hA5A5, 16'h5A5A, 0, 0);
        issue(OP_TICK, 0, 0, 0, 0, 0, 32'h0000_FFEF);
        issue(OP_TICK, 0, 0, 0, 0, 0, 32'h0001_0000);
        issue(OP_START, -32768, 0, 0, 0, 0, 0);
        // edit the frame that is playing, then restart it
        issue(OP_WRITE, 0, 1, 16'h0F0F, 16'hF0F0, 0, 0);
        issue(OP_START, 2, 0, 0, 0, 0, 5);
        issue(OP_STOP, 0, 0, 0, 0, 0, 0);
        issue(OP_TICK, 0, 0, 0, 0, 0, 6);
    endtask

    task automatic test_clear_and_empty();
        issue(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        issue(OP_START, 2, 0, 0, 0, 0, 50);
        issue(OP_SELECT, FRAMES - 1, 0, 0, 0, 0, 0);
        issue(OP_LINK, 0, 0, 0, 0, 0, 0);
        issue(OP_START, FRAMES - 1, 0, 0, 0, 0, 100);
        issue(OP_TICK, 0, 0, 0, 0, 0, 100);
        issue(OP_STOP, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        int f;
        int n;
        int fn;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    // program one frame: joints, wait and link
                    f = pick_frame();
                    issue(OP_SELECT, f, $urandom, $urandom, $urandom, $urandom, $urandom);
                    if ($urandom_range(0, 3) == 0)
                        issue(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        for (int j = 0; j < JOINTS; j++)
                            issue(OP_WRITE, $urandom, j, $urandom, $urandom, $urandom,
                                  $urandom);
                    end
                    else
                    begin
                        n = $urandom_range(1, 5);
                        repeat (n)
                            issue(OP_WRITE, $urandom,
                                  ($urandom_range(0, 19) == 0) ? $urandom_range(JOINTS, 255)
                                                               : $urandom_range(0, JOINTS - 1),
                                  $urandom, $urandom, $urandom, $urandom);
                    end
                    issue(OP_WAIT, $urandom, $urandom, $urandom, $urandom,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 30),
                          $urandom);
                    case ($urandom_range(0, 9))
                        0:       fn = END_LINK;
                        1:       fn = $urandom_range(FRAMES, 32767);
                        2:       fn = 0 - int'($urandom_range(2, 32768));
                        default: fn = pick_frame();
                    endcase
                    issue(OP_LINK, fn, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
                4, 5, 6, 7:
                begin
                    // play: start, then a run of ticks with the odd edit or stop
                    if ($urandom_range(0, 7) == 0)
                        wall_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
                    issue(OP_START, pick_frame(), $urandom, $urandom, $urandom, $urandom,
                          wall_ms);
                    n = $urandom_range(2, 10);
                    repeat (n) begin
                        wall_ms += $urandom_range(0, 25);
                        case ($urandom_range(0, 19))
                            0:
                                issue(OP_STOP, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom);
                            1:
                                if (play_idx >= 0)
                                begin
                                    issue(OP_SELECT, play_idx, $urandom, $urandom, $urandom,
                                          $urandom, $urandom);
                                    issue(OP_WRITE, $urandom, $urandom_range(0, JOINTS - 1),
                                          $urandom, $urandom, $urandom, $urandom);
                                end
                            default:
                                issue(OP_TICK, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, wall_ms);
                        endcase
                    end
                end
                default:
                    issue(3'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        cmd_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    always @(posedge clk)
    begin : check_commands
        cmd_t want;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (cmd_expect.size() == 0)
                report_error($sformatf("command for joint %0d with nothing expected",
                                       cmd_data.cmd_joint));
            else
            begin
                want = cmd_expect.pop_front();
                if (cmd_data.cmd_joint !== want.cmd_joint)
                    report_error($sformatf("cmd_joint got %0d, expected %0d",
                                           cmd_data.cmd_joint, want.cmd_joint));
                if (cmd_data.cmd_position !== want.cmd_position)
                    report_error($sformatf("cmd_position got 0x%0h, expected 0x%0h",
                                           cmd_data.cmd_position, want.cmd_position));
                if (cmd_data.cmd_speed !== want.cmd_speed)
                    report_error($sformatf("cmd_speed got 0x%0h, expected 0x%0h",
                                           cmd_data.cmd_speed, want.cmd_speed));
                if (cmd_data.last_command !== want.last_command)
                    report_error($sformatf("last_command got %b, expected %b on joint %0d",
                                           cmd_data.last_command, want.last_command,
                                           want.cmd_joint));
            end
            cmds_checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (cmd_valid && !cmd_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d commands outstanding",
                         WATCHDOG_CYCLES, cmd_expect.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        for (int k = 0; k < FRAMES*JOINTS; k++) begin
            tbl_pos[k] = '0;
            tbl_spd[k] = '0;
            tbl_set[k] = 1'b0;
        end
        for (int k = 0; k < FRAMES; k++) begin
            link_to[k] = 0;
            hold_ms[k] = '0;
        end
        edit_idx          = 0;
        play_idx          = END_LINK;
        play_t0           = '0;
        wall_ms           = $urandom;
        sender_idle_pct   = 16;
        receiver_idle_pct = 69;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_joint_writes();
        test_playback_wrap();
        test_clear_and_empty();
        test_random_traffic(50);
        sender_idle_pct   = 69;
        receiver_idle_pct = 16;
        test_random_traffic(50);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_traffic(50);
        req_valid <= 1'b0;

        while (cmd_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: joint edits, links, waits, start/stop and ticks", requests_sent);
        $display("Checked %0d commands, incl. wraparound timing and empty frames; %0d errors",
                 cmds_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
